// ===== rtl/mlhs_pkg.sv =====
// Shared types, widths and constants for the lower-half matrix multiply sum unit.
`default_nettype none

package mlhs_pkg;

    localparam int DATA_W      = 64;
    localparam int HALF_W      = 32;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 4;
    localparam int SIZE_W      = 5;
    localparam int MAX_DIM_DEF = 16;
    localparam int MIN_DIM     = 2;
    localparam int HALF_DIV    = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE_A = 2'd0,
        KIND_WRITE_B = 2'd1,
        KIND_RUN     = 2'd2,
        KIND_READ_C  = 2'd3
    } kind_t;

    typedef struct packed {
        logic load;
        logic clear;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mlhs_if.sv =====
// Valid/ready channel interfaces for command items and result items.
`default_nettype none

interface mlhs_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [mlhs_pkg::KIND_W-1:0]       kind;
    logic [mlhs_pkg::IDX_W-1:0]        row_index;
    logic [mlhs_pkg::IDX_W-1:0]        col_index;
    logic signed [mlhs_pkg::DATA_W-1:0] element_value;
    logic signed [mlhs_pkg::DATA_W-1:0] partner_sum;

    modport source (
        output valid, kind, row_index, col_index, element_value, partner_sum,
        input  ready
    );
    modport sink (
        input  valid, kind, row_index, col_index, element_value, partner_sum,
        output ready
    );
endinterface

interface mlhs_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [mlhs_pkg::DATA_W-1:0] result_value;
    logic                              is_sum;

    modport source (
        output valid, result_value, is_sum,
        input  ready
    );
    modport sink (
        input  valid, result_value, is_sum,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/mlhs_mac.sv =====
// Shared multiply-accumulate unit: 64x64 low product from three passes of one 32x32 multiplier.
`default_nettype none

module mlhs_mac (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mlhs_pkg::mac_ctl_t          ctl,
    input  wire logic [mlhs_pkg::DATA_W-1:0] op_a,
    input  wire logic [mlhs_pkg::DATA_W-1:0] op_b,
    output logic      [mlhs_pkg::DATA_W-1:0] acc,
    output logic                             busy
);
    import mlhs_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_LL   = 5'b00010,
        PH_LH   = 5'b00100,
        PH_HL   = 5'b01000,
        PH_LAST = 5'b10000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [DATA_W-1:0]   a_reg, b_reg;
    logic [DATA_W-1:0]   prod_reg, prod_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [DATA_W-1:0]   addend;

    always_comb
    begin
        mul_a      = a_reg[HALF_W-1:0];
        mul_b      = b_reg[HALF_W-1:0];
        addend     = '0;
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (ctl.load)
                begin
                    phase_next = PH_LL;
                end
            end
            PH_LL:
            begin
                phase_next = PH_LH;
            end
            PH_LH:
            begin
                // low x high cross term; add the low x low product
                mul_b      = b_reg[DATA_W-1:HALF_W];
                addend     = prod_reg;
                phase_next = PH_HL;
            end
            PH_HL:
            begin
                mul_a      = a_reg[DATA_W-1:HALF_W];
                addend     = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                phase_next = PH_LAST;
            end
            PH_LAST:
            begin
                addend     = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        prod_next = DATA_W'(mul_a) * DATA_W'(mul_b);
        acc_next  = ctl.clear ? '0 : acc_reg + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && ctl.load)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = (phase_reg != PH_IDLE);

endmodule

`default_nettype wire

// ===== rtl/matmul_lower_half_sum_unit.sv =====
// Lower-half matrix multiply with running sum: top level with stores and sequencer.
//
// Loads signed 64-bit matrices A and B one element per item (accepted back to
// back). A run item computes C[i][j] for rows size/2..size-1 and all columns
// below size, stores each element and returns the sum of them plus the item's
// partner_sum; all arithmetic wraps modulo 2^64. A read item returns one stored
// C element, read from the store into a register and then placed in the output
// register (zero if the index lies beyond the store). Each multiply-accumulate
// step reads the A/B stores, then loads the MAC, then waits on the shared 32x32
// multiplier, which makes three passes per 64-bit product. The block accepts
// no item while a run or read is in progress; writes are taken even while a
// result waits at the output. The configured size is clamped to 2..MAX_DIM.
`default_nettype none

module matmul_lower_half_sum_unit #(
    parameter int MAX_DIM = mlhs_pkg::MAX_DIM_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic [mlhs_pkg::SIZE_W-1:0] cfg_write_data,
    mlhs_cmd_if.sink                         cmd,
    mlhs_rsp_if.source                       rsp
);
    import mlhs_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [IW-1:0]       n_last_reg, n_last_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [IW-1:0]       j_reg, j_next;
    logic [IW-1:0]       k_reg, k_next;
    logic [DATA_W-1:0]   sum_reg, sum_next;
    logic [DATA_W-1:0]   partner_reg;
    logic                rd_inside_reg;
    logic [DATA_W-1:0]   a_rd_reg, b_rd_reg, c_rd_reg;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    logic                out_is_sum_reg, out_is_sum_next;

    logic [DATA_W-1:0]   mem_a [DEPTH];
    logic [DATA_W-1:0]   mem_b [DEPTH];
    logic [DATA_W-1:0]   mem_c [DEPTH];

    kind_t               cmd_kind;
    logic                cmd_accept;
    logic                cmd_inside;
    logic [AW-1:0]       cmd_addr;
    logic [AW-1:0]       a_addr, b_addr, c_addr;
    logic [NW-1:0]       n_clamped;
    logic                out_free;

    mac_ctl_t            mac_ctl;
    logic [DATA_W-1:0]   mac_acc;
    logic                mac_busy;

    mlhs_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (a_rd_reg),
        .op_b  (b_rd_reg),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    assign cmd_kind   = kind_t'(cmd.kind);
    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign cmd_inside = (32'(cmd.row_index) < 32'(MAX_DIM))
                     && (32'(cmd.col_index) < 32'(MAX_DIM));
    assign cmd_addr   = AW'(cmd.row_index) * DIM_A + AW'(cmd.col_index);
    assign a_addr     = AW'(i_reg) * DIM_A + AW'(k_reg);
    assign b_addr     = AW'(k_reg) * DIM_A + AW'(j_reg);
    assign c_addr     = AW'(i_reg) * DIM_A + AW'(j_reg);
    assign out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (32'(size_reg) < 32'(MIN_DIM))
        begin
            n_clamped = NW'(MIN_DIM);
        end
        else if (32'(size_reg) > 32'(MAX_DIM))
        begin
            n_clamped = NW'(MAX_DIM);
        end
        else
        begin
            n_clamped = NW'(size_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        n_last_next     = n_last_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_is_sum_next = out_is_sum_reg;
        mac_ctl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd_kind)
                        KIND_RUN:
                        begin
                            n_last_next   = IW'(n_clamped - NW'(1));
                            i_next        = IW'(n_clamped / HALF_DIV);
                            j_next        = '0;
                            k_next        = '0;
                            sum_next      = '0;
                            mac_ctl.clear = 1'b1;
                            state_next    = S_FETCH;
                        end
                        KIND_READ_C:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // hold the read data until the output slot frees up
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_inside_reg ? c_rd_reg : '0;
                    out_is_sum_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                mac_ctl.load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                if (!mac_busy)
                begin
                    if (k_reg == n_last_reg)
                    begin
                        state_next = S_STORE;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            S_STORE:
            begin
                sum_next      = sum_reg + mac_acc;
                mac_ctl.clear = 1'b1;
                k_next        = '0;
                if (j_reg == n_last_reg)
                begin
                    j_next = '0;
                    if (i_reg == n_last_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_FETCH;
                    end
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = sum_reg + partner_reg;
                    out_is_sum_next = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                size_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_last_reg     <= n_last_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        sum_reg        <= sum_next;
        out_value_reg  <= out_value_next;
        out_is_sum_reg <= out_is_sum_next;
        if (cmd_accept)
        begin
            partner_reg   <= cmd.partner_sum;
            rd_inside_reg <= cmd_inside;
        end
    end

    // operand stores: written by load items, read once per MAC step
    always_ff @(posedge clk)
    begin
        if (cmd_accept && cmd_inside && cmd_kind == KIND_WRITE_A)
        begin
            mem_a[cmd_addr] <= cmd.element_value;
        end
        if (state_reg == S_FETCH)
        begin
            a_rd_reg <= mem_a[a_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept && cmd_inside && cmd_kind == KIND_WRITE_B)
        begin
            mem_b[cmd_addr] <= cmd.element_value;
        end
        if (state_reg == S_FETCH)
        begin
            b_rd_reg <= mem_b[b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_STORE)
        begin
            mem_c[c_addr] <= mac_acc;
        end
        if (cmd_accept)
        begin
            c_rd_reg <= mem_c[cmd_addr];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.is_sum       = out_is_sum_reg;

endmodule

`default_nettype wire

// ===== rtl/mlhs_checker.sv =====
// Port-level checker for the lower-half matrix multiply sum unit, bound to the top level.
`default_nettype none

module mlhs_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        cmd_valid,
    input wire logic                        cmd_ready,
    input wire logic [mlhs_pkg::KIND_W-1:0] cmd_kind,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [mlhs_pkg::DATA_W-1:0] rsp_result_value,
    input wire logic                        rsp_is_sum
);
    import mlhs_pkg::*;

    logic cmd_fire;
    logic cmd_busy_kind;
    logic cmd_load_kind;

    assign cmd_fire      = cmd_valid && cmd_ready;
    assign cmd_busy_kind = (cmd_kind == KIND_RUN) || (cmd_kind == KIND_READ_C);
    assign cmd_load_kind = (cmd_kind == KIND_WRITE_A) || (cmd_kind == KIND_WRITE_B);

    // a run or read occupies the block for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd_busy_kind |=> !cmd_ready)
        else $error("cmd accepted during run or read");

    // a load item never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd_load_kind && !rsp_valid |=> !rsp_valid)
        else $error("result appeared after load item");

    // a read result cannot appear in the cycle right after the read is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (cmd_kind == KIND_READ_C) && !rsp_valid |=> !rsp_valid)
        else $error("read result too early");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_result_value) && $stable(rsp_is_sum))
        else $error("stalled result changed");

endmodule

bind matmul_lower_half_sum_unit mlhs_checker u_mlhs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .cmd_kind         (cmd.kind),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_value (rsp.result_value),
    .rsp_is_sum       (rsp.is_sum)
);

`default_nettype wire
